/* sv/rct_pkg.sv */
package rct_pkg;

    localparam int STATE_SIZE_DEF  = 64;
    localparam int INPUT_SIZE_DEF  = 64;
    localparam int SLOTS_DEF       = 8;

    // tanh input saturates to this signed width
    localparam int DATA_WIDTH      = 16;
    localparam int ACC_W           = 48;
    localparam int VAL_W           = 16;
    localparam int HID_W           = 14;
    localparam int CFG_W           = 7;
    localparam int CMD_QUEUE_DEPTH = 2;

    localparam logic CFG_STATE_IN_USE  = 1'b0;
    localparam logic CFG_INPUTS_IN_USE = 1'b1;

    localparam logic [2:0] OP_IN_W   = 3'd0;
    localparam logic [2:0] OP_REC_W  = 3'd1;
    localparam logic [2:0] OP_BIAS   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_ELEM   = 3'd4;

    typedef enum logic [2:0] {
        K_IN_W  = 3'd0,
        K_REC_W = 3'd1,
        K_BIAS  = 3'd2,
        K_CLEAR = 3'd3,
        K_ELEM  = 3'd4,
        K_STEP  = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [2:0]                slot;
        logic [5:0]                row;
        logic [5:0]                col;
        logic signed [VAL_W-1:0]   value;
        logic                      emit;
    } rct_cmd_t;

    // round(4096*tanh(k/4)), k = 0..16
    function automatic logic [11:0] rct_tanh_tab(input logic [4:0] idx);
        logic [11:0] y;
        case (idx)
            5'd0:    y = 12'd0;
            5'd1:    y = 12'd1003;
            5'd2:    y = 12'd1893;
            5'd3:    y = 12'd2602;
            5'd4:    y = 12'd3119;
            5'd5:    y = 12'd3475;
            5'd6:    y = 12'd3707;
            5'd7:    y = 12'd3856;
            5'd8:    y = 12'd3949;
            5'd9:    y = 12'd4006;
            5'd10:   y = 12'd4041;
            5'd11:   y = 12'd4063;
            5'd12:   y = 12'd4076;
            5'd13:   y = 12'd4084;
            5'd14:   y = 12'd4089;
            5'd15:   y = 12'd4091;
            default: y = 12'd4093;
        endcase
        return y;
    endfunction

endpackage

/* sv/rnn_cell_tanh_step.sv */
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    opcode slot row col value emit
// result    out        out_valid / out_ready  out_slot unit_index hidden_value last
// config    in         cfg_we (no wait)       cfg_index cfg_data
//
// Weight, bias and element items are stored straight from the idle state.
// A clear zeroes every unit of its slot. A step runs on one MAC unit: it
// issues input then recurrent products for every hidden unit, drains the
// pipeline, then copies each hidden unit back and emits it if asked.
// After reset the hidden store is swept to zero; no item is taken until
// then. A stalled result stops only the copy.
module rnn_cell_tanh_step #(
    parameter int STATE_SIZE = rct_pkg::STATE_SIZE_DEF,
    parameter int INPUT_SIZE = rct_pkg::INPUT_SIZE_DEF,
    parameter int SLOTS      = rct_pkg::SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rct_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        opcode,
    input  logic [2:0]                        slot,
    input  logic [5:0]                        row,
    input  logic [5:0]                        col,
    input  logic signed [rct_pkg::VAL_W-1:0]  value,
    input  logic                              emit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        out_slot,
    output logic [5:0]                        unit_index,
    output logic signed [rct_pkg::HID_W-1:0]  hidden_value,
    output logic                              last
);
    import rct_pkg::*;

    logic [CFG_W-1:0] state_in_use_reg;
    logic [CFG_W-1:0] inputs_in_use_reg;
    logic [CFG_W-1:0] ns;
    logic [CFG_W-1:0] ni;
    logic             init_busy;
    logic             q_full, q_push, q_pop, q_valid;
    rct_cmd_t         cmd_in, cmd_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_in_use_reg  <= CFG_W'(64);
            inputs_in_use_reg <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATE_IN_USE:  state_in_use_reg  <= cfg_data;
                CFG_INPUTS_IN_USE: inputs_in_use_reg <= cfg_data;
                default:           state_in_use_reg  <= state_in_use_reg;
            endcase
        end
    end

    // zero acts as one, over-range acts as the store size
    always_comb
    begin
        if (state_in_use_reg == '0)
            ns = CFG_W'(1);
        else if (int'(state_in_use_reg) > STATE_SIZE)
            ns = CFG_W'(STATE_SIZE);
        else
            ns = state_in_use_reg;
        if (inputs_in_use_reg == '0)
            ni = CFG_W'(1);
        else if (int'(inputs_in_use_reg) > INPUT_SIZE)
            ni = CFG_W'(INPUT_SIZE);
        else
            ni = inputs_in_use_reg;
    end

    rct_front #(
        .STATE_SIZE (STATE_SIZE),
        .INPUT_SIZE (INPUT_SIZE),
        .SLOTS      (SLOTS)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .slot      (slot),
        .row       (row),
        .col       (col),
        .value     (value),
        .emit      (emit),
        .ni        (ni),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .cmd       (cmd_in)
    );

    rct_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (cmd_out),
        .valid (q_valid)
    );

    rct_back #(
        .STATE_SIZE (STATE_SIZE),
        .INPUT_SIZE (INPUT_SIZE),
        .SLOTS      (SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ns           (ns),
        .ni           (ni),
        .cmd_valid    (q_valid),
        .cmd          (cmd_out),
        .cmd_pop      (q_pop),
        .init_busy    (init_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_slot     (out_slot),
        .unit_index   (unit_index),
        .hidden_value (hidden_value),
        .last         (last)
    );

endmodule

/* sv/rct_front.sv */
module rct_front #(
    parameter int STATE_SIZE = rct_pkg::STATE_SIZE_DEF,
    parameter int INPUT_SIZE = rct_pkg::INPUT_SIZE_DEF,
    parameter int SLOTS      = rct_pkg::SLOTS_DEF
) (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        opcode,
    input  logic [2:0]                        slot,
    input  logic [5:0]                        row,
    input  logic [5:0]                        col,
    input  logic signed [rct_pkg::VAL_W-1:0]  value,
    input  logic                              emit,
    input  logic [rct_pkg::CFG_W-1:0]         ni,
    input  logic                              init_busy,
    input  logic                              q_full,
    output logic                              q_push,
    output rct_pkg::rct_cmd_t                 cmd
);
    import rct_pkg::*;

    logic keep;
    logic row_ok;
    logic col_in_ok;
    logic col_rec_ok;
    logic slot_ok;
    logic is_last_elem;

    assign row_ok       = int'(row) < STATE_SIZE;
    assign col_in_ok    = int'(col) < INPUT_SIZE;
    assign col_rec_ok   = int'(col) < STATE_SIZE;
    assign slot_ok      = int'(slot) < SLOTS;
    assign is_last_elem = {1'b0, col} == (ni - 7'd1);

    assign in_ready = !q_full && !init_busy;
    assign q_push   = in_valid && in_ready && keep;

    always_comb
    begin
        cmd.slot  = slot;
        cmd.row   = row;
        cmd.col   = col;
        cmd.value = value;
        cmd.emit  = emit;
        cmd.kind  = K_ELEM;
        keep      = 1'b0;
        case (opcode)
            OP_IN_W:
            begin
                cmd.kind = K_IN_W;
                keep     = row_ok && col_in_ok;
            end
            OP_REC_W:
            begin
                cmd.kind = K_REC_W;
                keep     = row_ok && col_rec_ok;
            end
            OP_BIAS:
            begin
                cmd.kind = K_BIAS;
                keep     = row_ok;
            end
            OP_CLEAR:
            begin
                cmd.kind = K_CLEAR;
                keep     = slot_ok;
            end
            OP_ELEM:
            begin
                // element for a slot out of range is stored, no step
                cmd.kind = (is_last_elem && slot_ok) ? K_STEP : K_ELEM;
                keep     = col_in_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

/* sv/rct_fifo.sv */
module rct_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rct_pkg::rct_cmd_t  din,
    output logic               full,
    input  logic               pop,
    output rct_pkg::rct_cmd_t  dout,
    output logic               valid
);
    import rct_pkg::*;

    localparam int DEPTH = CMD_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rct_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* sv/rct_back.sv */
module rct_back #(
    parameter int STATE_SIZE = rct_pkg::STATE_SIZE_DEF,
    parameter int INPUT_SIZE = rct_pkg::INPUT_SIZE_DEF,
    parameter int SLOTS      = rct_pkg::SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rct_pkg::CFG_W-1:0]         ns,
    input  logic [rct_pkg::CFG_W-1:0]         ni,
    input  logic                              cmd_valid,
    input  rct_pkg::rct_cmd_t                 cmd,
    output logic                              cmd_pop,
    output logic                              init_busy,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        out_slot,
    output logic [5:0]                        unit_index,
    output logic signed [rct_pkg::HID_W-1:0]  hidden_value,
    output logic                              last
);
    import rct_pkg::*;

    localparam int WDEPTH = STATE_SIZE * INPUT_SIZE;
    localparam int UDEPTH = STATE_SIZE * STATE_SIZE;
    localparam int HDEPTH = SLOTS * STATE_SIZE;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int UA_W   = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
    localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int SA_W   = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
    localparam int XA_W   = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1 <<< (DATA_WIDTH - 1));

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CLEAR = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_COPY  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         slot_reg, slot_next;
    logic               emit_reg, emit_next;
    logic [5:0]         j_reg, j_next;
    logic [6:0]         k_reg, k_next;
    logic               phb_reg, phb_next;
    logic [HA_W-1:0]    sweep_reg, sweep_next;
    logic [5:0]         cp_j_reg, cp_j_next;
    logic               cp_pend_reg, cp_pend_next;

    // memories
    logic signed [VAL_W-1:0] w_mem  [WDEPTH];
    logic signed [VAL_W-1:0] u_mem  [UDEPTH];
    logic signed [VAL_W-1:0] b_mem  [STATE_SIZE];
    logic signed [VAL_W-1:0] x_mem  [INPUT_SIZE];
    logic signed [HID_W-1:0] h_mem  [HDEPTH];
    logic signed [HID_W-1:0] nh_mem [STATE_SIZE];

    logic signed [VAL_W-1:0] w_q, u_q, b_q, x_q;
    logic signed [HID_W-1:0] h_q, nh_q;

    logic                    w_we, u_we, b_we, x_we, h_we, nh_we;
    logic [HA_W-1:0]         h_waddr;
    logic signed [HID_W-1:0] h_wdata;

    // MAC pipeline
    logic                    issue;
    logic                    is_first, is_lastel;
    logic                    s1_valid_reg, s1_phb_reg, s1_first_reg, s1_last_reg;
    logic [5:0]              s1_unit_reg;
    logic                    s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [5:0]              s2_unit_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [VAL_W-1:0] bias_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_base;
    logic                    s3_valid_reg;
    logic [5:0]              s3_unit_reg;
    logic                    t_valid_reg, t_neg_reg, t_big_reg;
    logic [5:0]              t_unit_reg;
    logic [3:0]              t_idx_reg;
    logic [9:0]              t_frac_reg;
    logic                    pipe_busy;

    logic signed [ACC_W-1:0]      fl;
    logic signed [DATA_WIDTH-1:0] sat_v;
    logic [DATA_WIDTH-1:0]        mag;

    logic [11:0]             y0, y1, ymag;
    logic [10:0]             dy;
    logic [20:0]             interp;
    logic signed [HID_W-1:0] y_signed;

    logic                    out_free, out_load;
    logic signed [VAL_W-1:0] op_a, op_b;

    assign init_busy = state_reg == ST_INIT;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign issue     = state_reg == ST_MAC;
    assign is_first  = !phb_reg && (k_reg == 7'd0);
    assign is_lastel = phb_reg && (k_reg == ns - 7'd1);
    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || t_valid_reg;
    assign out_free  = !out_valid || out_ready;

    assign w_we = cmd_pop && (cmd.kind == K_IN_W);
    assign u_we = cmd_pop && (cmd.kind == K_REC_W);
    assign b_we = cmd_pop && (cmd.kind == K_BIAS);
    assign x_we = cmd_pop && ((cmd.kind == K_ELEM) || (cmd.kind == K_STEP));

    // copy stage retires one unit once the output register can take it, or at once when not emitting
    assign out_load = (state_reg == ST_COPY) && cp_pend_reg && (!emit_reg || out_free);

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        emit_next    = emit_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        phb_next     = phb_reg;
        sweep_next   = sweep_reg;
        cp_j_next    = cp_j_reg;
        cp_pend_next = cp_pend_reg;
        h_we         = 1'b0;
        h_waddr      = sweep_reg;
        h_wdata      = '0;
        case (state_reg)
            ST_INIT:
            begin
                h_we       = 1'b1;
                h_waddr    = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == HA_W'(HDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        K_CLEAR:
                        begin
                            slot_next  = cmd.slot;
                            k_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        K_STEP:
                        begin
                            slot_next  = cmd.slot;
                            emit_next  = cmd.emit;
                            j_next     = '0;
                            k_next     = '0;
                            phb_next   = 1'b0;
                            state_next = ST_MAC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                h_we    = 1'b1;
                h_waddr = HA_W'(int'(slot_reg) * STATE_SIZE + int'(k_reg));
                k_next  = k_reg + 7'd1;
                if (k_reg == 7'(STATE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                if (!phb_reg)
                begin
                    if (k_reg == ni - 7'd1)
                    begin
                        phb_next = 1'b1;
                        k_next   = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 7'd1;
                    end
                end
                else if (is_lastel)
                begin
                    phb_next = 1'b0;
                    k_next   = '0;
                    if ({1'b0, j_reg} == ns - 7'd1)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 6'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 7'd1;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    cp_j_next    = '0;
                    cp_pend_next = 1'b0;
                    state_next   = ST_COPY;
                end
            end
            ST_COPY:
            begin
                h_waddr = HA_W'(int'(slot_reg) * STATE_SIZE + int'(cp_j_reg));
                h_wdata = nh_q;
                if (!cp_pend_reg)
                begin
                    cp_pend_next = 1'b1;
                end
                else if (out_load)
                begin
                    h_we         = 1'b1;
                    cp_pend_next = 1'b0;
                    if ({1'b0, cp_j_reg} == ns - 7'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cp_j_next = cp_j_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            slot_reg     <= '0;
            emit_reg     <= 1'b0;
            j_reg        <= '0;
            k_reg        <= '0;
            phb_reg      <= 1'b0;
            sweep_reg    <= '0;
            cp_j_reg     <= '0;
            cp_pend_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            emit_reg     <= emit_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            phb_reg      <= phb_next;
            sweep_reg    <= sweep_next;
            cp_j_reg     <= cp_j_next;
            cp_pend_reg  <= cp_pend_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            t_valid_reg  <= s3_valid_reg;
            if (out_load && emit_reg)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[WA_W'(int'(cmd.row) * INPUT_SIZE + int'(cmd.col))] <= cmd.value;
        end
        w_q <= w_mem[WA_W'(int'(j_reg) * INPUT_SIZE + int'(k_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            u_mem[UA_W'(int'(cmd.row) * STATE_SIZE + int'(cmd.col))] <= cmd.value;
        end
        u_q <= u_mem[UA_W'(int'(j_reg) * STATE_SIZE + int'(k_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[SA_W'(cmd.row)] <= cmd.value;
        end
        b_q <= b_mem[SA_W'(j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[XA_W'(cmd.col)] <= cmd.value;
        end
        x_q <= x_mem[XA_W'(k_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        h_q <= h_mem[HA_W'(int'(slot_reg) * STATE_SIZE + int'(k_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (nh_we)
        begin
            nh_mem[SA_W'(t_unit_reg)] <= y_signed;
        end
        nh_q <= nh_mem[SA_W'(cp_j_reg)];
    end

    // multiply and accumulate
    assign op_a     = s1_phb_reg ? u_q : w_q;
    assign op_b     = s1_phb_reg ? VAL_W'(h_q) : x_q;
    assign acc_base = s2_first_reg ? (ACC_W'(bias_reg) <<< 12) : acc_reg;

    always_ff @(posedge clk)
    begin
        s1_phb_reg   <= phb_reg;
        s1_first_reg <= is_first;
        s1_last_reg  <= is_lastel;
        s1_unit_reg  <= j_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg && s1_valid_reg;
        s2_unit_reg  <= s1_unit_reg;
        prod_reg     <= op_a * op_b;
        bias_reg     <= b_q;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
        s3_unit_reg  <= s2_unit_reg;
    end

    // floor to Q4.12, saturate, split magnitude for the table
    always_comb
    begin
        fl = acc_reg >>> 12;
        if (fl > SAT_HI)
        begin
            sat_v = DATA_WIDTH'(SAT_HI);
        end
        else if (fl < SAT_LO)
        begin
            sat_v = DATA_WIDTH'(SAT_LO);
        end
        else
        begin
            sat_v = DATA_WIDTH'(fl);
        end
        mag = sat_v[DATA_WIDTH-1] ? (~sat_v + 1'b1) : sat_v;
    end

    always_ff @(posedge clk)
    begin
        t_unit_reg <= s3_unit_reg;
        t_neg_reg  <= sat_v[DATA_WIDTH-1];
        t_big_reg  <= mag >= DATA_WIDTH'(16384);
        t_idx_reg  <= mag[13:10];
        t_frac_reg <= mag[9:0];
    end

    // linear interpolation between table points
    always_comb
    begin
        y0     = rct_tanh_tab({1'b0, t_idx_reg});
        y1     = rct_tanh_tab({1'b0, t_idx_reg} + 5'd1);
        dy     = 11'(y1 - y0);
        interp = (21'(dy) * 21'(t_frac_reg) + 21'd512) >> 10;
        ymag   = t_big_reg ? rct_tanh_tab(5'd16) : (y0 + interp[11:0]);
        y_signed = t_neg_reg ? -HID_W'(ymag) : HID_W'(ymag);
    end

    assign nh_we = t_valid_reg;

    always_ff @(posedge clk)
    begin
        if (out_load && emit_reg)
        begin
            out_slot     <= slot_reg;
            unit_index   <= cp_j_reg;
            hidden_value <= nh_q;
            last         <= {1'b0, cp_j_reg} == ns - 7'd1;
        end
    end

endmodule

/* sv/rct_checker.sv */
module rct_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [2:0]                        out_slot,
    input logic [5:0]                        unit_index,
    input logic signed [rct_pkg::HID_W-1:0]  hidden_value,
    input logic                              last
);
    import rct_pkg::*;

    // a result waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before accept");

    // tanh never leaves its range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hidden_value <= 14'sd4093) && (hidden_value >= -14'sd4093))
        else $error("hidden value out of range");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result during reset");

    // hidden store sweep blocks input right after reset
    a_sweep_blocks: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("item taken during clearing sweep");

endmodule

bind rnn_cell_tanh_step rct_checker u_chk (.*);
